FILE: rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at the same edge.
`define TBPF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the following edge.
`define TBPF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tbpf_pkg.sv
// Shared types, constants and helper functions of the background pixel fetch.
package tbpf_pkg;

   localparam int VRAM_BYTES       = 8192;
   localparam int VRAM_AW          = 13;
   localparam int SCREEN_WIDTH_DEF = 160;
   localparam int QUEUE_DEPTH_DEF  = 4;
   localparam int CSR_INDEX_W      = 2;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_LCD_CONTROL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCROLL_Y    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCROLL_X    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BG_PALETTE  = 2'd3;

   // lcd_control bit positions
   localparam int LCDC_BG_ENABLE    = 0;
   localparam int LCDC_MAP_SELECT   = 3;
   localparam int LCDC_DATA_UNSIGNED = 4;

   // video memory layout (offsets from the start of video memory)
   localparam logic [VRAM_AW-1:0] MAP_LOW_BASE       = 13'h1800;
   localparam logic [VRAM_AW-1:0] MAP_HIGH_BASE      = 13'h1C00;
   localparam logic [VRAM_AW-1:0] TILE_UNSIGNED_BASE = 13'h0000;
   // signed tiles sit around 0x1000: base of tile -128 is 0x0800
   localparam logic [VRAM_AW-1:0] TILE_SIGNED_BASE   = 13'h0800;
   localparam logic [7:0]         TILE_SIGN_FLIP     = 8'h80;

   localparam logic [31:0] ARGB_WHITE      = 32'hFFFFFFFF;
   localparam logic [31:0] ARGB_LIGHT_GREY = 32'hFFAAAAAA;
   localparam logic [31:0] ARGB_DARK_GREY  = 32'hFF555555;
   localparam logic [31:0] ARGB_BLACK      = 32'hFF000000;

   // one queued beat, already classified by the front
   typedef struct packed {
      logic               is_pixel;
      logic               bg_on;
      logic               data_unsigned;
      logic [VRAM_AW-1:0] addr;        // write offset, or tile map address
      logic [7:0]         wdata;
      logic [2:0]         fine_y;
      logic [2:0]         fine_x;
      logic [14:0]        pix_index;
   } entry_type;

   function automatic logic [31:0] shade_color(input logic [1:0] shade);
      logic [31:0] color;
      case (shade)
         2'd0:    color = ARGB_WHITE;
         2'd1:    color = ARGB_LIGHT_GREY;
         2'd2:    color = ARGB_DARK_GREY;
         default: color = ARGB_BLACK;
      endcase
      return color;
   endfunction

endpackage

FILE: rtl/tbpf_ram.sv
// Generic single-port RAM with registered read data.
module tbpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/tbpf_fifo.sv
// Short queue of classified beats between the front and the back.
module tbpf_fifo
   import tbpf_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      full,
   output logic      empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   entry_type         slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/tbpf_front.sv
// Front: config registers, request acceptance and classification into queue beats.
module tbpf_front
   import tbpf_pkg::*;
#(
   parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_mode,
   input  logic [VRAM_AW-1:0]     req_vram_offset,
   input  logic [7:0]             req_write_data,
   input  logic [7:0]             req_line,
   input  logic [7:0]             req_column,
   input  logic                   queue_full,
   output logic                   push,
   output entry_type              push_entry,
   output logic [7:0]             bg_palette
);

   logic [7:0]  lcd_control_ff, lcd_control_in;
   logic [7:0]  scroll_y_ff, scroll_y_in;
   logic [7:0]  scroll_x_ff, scroll_x_in;
   logic [7:0]  bg_palette_ff, bg_palette_in;
   logic [7:0]  y_pos, x_pos;
   logic [16:0] row_start, pix_sum;
   logic [VRAM_AW-1:0] map_base;

   always_comb begin
      lcd_control_in = lcd_control_ff;
      scroll_y_in    = scroll_y_ff;
      scroll_x_in    = scroll_x_ff;
      bg_palette_in  = bg_palette_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LCD_CONTROL: lcd_control_in = csr_wdata;
            CSR_SCROLL_Y:    scroll_y_in    = csr_wdata;
            CSR_SCROLL_X:    scroll_x_in    = csr_wdata;
            CSR_BG_PALETTE:  bg_palette_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcd_control_ff <= '0;
         scroll_y_ff    <= '0;
         scroll_x_ff    <= '0;
         bg_palette_ff  <= '0;
      end else begin
         lcd_control_ff <= lcd_control_in;
         scroll_y_ff    <= scroll_y_in;
         scroll_x_ff    <= scroll_x_in;
         bg_palette_ff  <= bg_palette_in;
      end
   end

   assign bg_palette = bg_palette_ff;
   assign req_ready  = !queue_full;
   assign push       = req_valid && !queue_full;

   // scroll wraps at 256 by the 8-bit sum
   assign y_pos     = req_line + scroll_y_ff;
   assign x_pos     = req_column + scroll_x_ff;
   assign map_base  = lcd_control_ff[LCDC_MAP_SELECT] ? MAP_HIGH_BASE : MAP_LOW_BASE;
   assign row_start = 17'(req_line) * 17'(SCREEN_WIDTH);
   assign pix_sum   = row_start + 17'(req_column);

   always_comb begin
      push_entry.is_pixel      = req_mode;
      push_entry.bg_on         = lcd_control_ff[LCDC_BG_ENABLE];
      push_entry.data_unsigned = lcd_control_ff[LCDC_DATA_UNSIGNED];
      push_entry.wdata         = req_write_data;
      push_entry.fine_y        = y_pos[2:0];
      push_entry.fine_x        = x_pos[2:0];
      push_entry.pix_index     = pix_sum[14:0];
      // a write carries its offset, a pixel the tile map byte address
      push_entry.addr          = req_mode ? (map_base + {3'b000, y_pos[7:3], x_pos[7:3]})
                                          : req_vram_offset;
   end

endmodule

FILE: rtl/tbpf_back.sv
// Back: video memory sequencer, shade lookup and result register.
module tbpf_back
   import tbpf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  entry_type   head,
   input  logic        queue_empty,
   output logic        pop,
   input  logic [7:0]  bg_palette,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_drawn,
   output logic [1:0]  rsp_shade,
   output logic [31:0] rsp_color_argb,
   output logic [14:0] rsp_pixel_index
);

   localparam logic [1:0] ST_IDLE = 2'd0;  // port free
   localparam logic [1:0] ST_TILE = 2'd1;  // tile number on read data
   localparam logic [1:0] ST_LO   = 2'd2;  // low plane on read data
   localparam logic [1:0] ST_HI   = 2'd3;  // high plane on read data

   logic [1:0]          state_ff, state_in;
   entry_type           cur_ff, cur_in;
   logic [VRAM_AW-1:0]  row_addr_ff, row_addr_in;
   logic [7:0]          lo_ff, lo_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_drawn_ff, rsp_drawn_in;
   logic [1:0]          rsp_shade_ff, rsp_shade_in;
   logic [31:0]         rsp_color_ff, rsp_color_in;
   logic [14:0]         rsp_index_ff, rsp_index_in;

   logic                ram_en, ram_we;
   logic [VRAM_AW-1:0]  ram_addr;
   logic [7:0]          ram_rdata;

   logic                out_free, slot_open, head_off, finish;
   logic [VRAM_AW-1:0]  tile_row_addr;
   logic [2:0]          bit_sel;
   logic [1:0]          cnum;
   logic [7:0]          pal_shifted;
   logic [1:0]          shade;

   tbpf_ram #(
      .WIDTH(8),
      .DEPTH(VRAM_BYTES)
   ) u_vram (
      .clock(clock),
      .en   (ram_en),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(head.wdata),
      .rdata(ram_rdata)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign finish    = (state_ff == ST_HI) && out_free;
   assign slot_open = (state_ff == ST_IDLE) || finish;
   assign head_off  = head.is_pixel && !head.bg_on;
   // a disabled pixel needs the result register, so it only leaves from idle
   assign pop = !queue_empty && slot_open &&
                (!head_off || ((state_ff == ST_IDLE) && out_free));

   always_comb begin
      if (cur_ff.data_unsigned) begin
         tile_row_addr = TILE_UNSIGNED_BASE + {1'b0, ram_rdata, cur_ff.fine_y, 1'b0};
      end else begin
         tile_row_addr = TILE_SIGNED_BASE +
                         {1'b0, ram_rdata ^ TILE_SIGN_FLIP, cur_ff.fine_y, 1'b0};
      end
   end

   assign bit_sel     = 3'd7 - cur_ff.fine_x;
   assign cnum        = {ram_rdata[bit_sel], lo_ff[bit_sel]};
   assign pal_shifted = bg_palette >> {cnum, 1'b0};
   assign shade       = pal_shifted[1:0];

   always_comb begin
      ram_en   = 1'b0;
      ram_we   = 1'b0;
      ram_addr = head.addr;
      case (state_ff)
         ST_TILE: begin
            ram_en   = 1'b1;
            ram_addr = tile_row_addr;
         end
         ST_LO: begin
            ram_en   = 1'b1;
            ram_addr = {row_addr_ff[VRAM_AW-1:1], 1'b1};
         end
         default: begin
            if (pop && !head_off) begin
               ram_en = 1'b1;
               ram_we = !head.is_pixel;
            end
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      row_addr_in = row_addr_ff;
      lo_in       = lo_ff;
      case (state_ff)
         ST_TILE: begin
            row_addr_in = tile_row_addr;
            state_in    = ST_LO;
         end
         ST_LO: begin
            lo_in    = ram_rdata;
            state_in = ST_HI;
         end
         default: begin
            // hold in ST_HI while the result register is stalled
            if (slot_open) begin
               state_in = (pop && head.is_pixel && head.bg_on) ? ST_TILE : ST_IDLE;
            end
         end
      endcase
      if (pop) begin
         cur_in = head;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_drawn_in = rsp_drawn_ff;
      rsp_shade_in = rsp_shade_ff;
      rsp_color_in = rsp_color_ff;
      rsp_index_in = rsp_index_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_drawn_in = 1'b1;
         rsp_shade_in = shade;
         rsp_color_in = shade_color(shade);
         rsp_index_in = cur_ff.pix_index;
      end else if (pop && head_off) begin
         rsp_valid_in = 1'b1;
         rsp_drawn_in = 1'b0;
         rsp_shade_in = '0;
         rsp_color_in = '0;
         rsp_index_in = head.pix_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      row_addr_ff  <= row_addr_in;
      lo_ff        <= lo_in;
      rsp_drawn_ff <= rsp_drawn_in;
      rsp_shade_ff <= rsp_shade_in;
      rsp_color_ff <= rsp_color_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drawn       = rsp_drawn_ff;
   assign rsp_shade       = rsp_shade_ff;
   assign rsp_color_argb  = rsp_color_ff;
   assign rsp_pixel_index = rsp_index_ff;

endmodule

FILE: rtl/tile_background_pixel_fetch.sv
// Top level of the background pixel fetch: front, beat queue and memory back end.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------
//   req     | in        | req_valid/ready    | mode, vram_offset, write_data, line, column
//   rsp     | out       | rsp_valid/ready    | drawn, shade, color_argb, pixel_index
//   csr     | in        | csr_we, no wait    | csr_index, csr_wdata
//
// A pixel beat with background on runs through the back-end states ST_TILE, ST_LO and
// ST_HI: tile map byte, low plane byte and high plane byte are three dependent reads of
// the single-port video memory; a write beat or a background-off pixel is done on pop.
// A drawn pixel goes from req acceptance via the queue and those states to rsp_valid.
// Reset clears control state only; video memory content is not cleared.
// The queue lets the front keep accepting while the back end works or rsp stalls;
// req_ready drops only when the queue is full.
module tile_background_pixel_fetch
   import tbpf_pkg::*;
#(
   parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_mode,
   input  logic [VRAM_AW-1:0]     req_vram_offset,
   input  logic [7:0]             req_write_data,
   input  logic [7:0]             req_line,
   input  logic [7:0]             req_column,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_drawn,
   output logic [1:0]             rsp_shade,
   output logic [31:0]            rsp_color_argb,
   output logic [14:0]            rsp_pixel_index
);

   entry_type  push_entry;
   entry_type  head;
   logic       push, pop;
   logic       queue_full, queue_empty;
   logic [7:0] bg_palette;

   // accept and classify: scroll, map address, pixel index
   tbpf_front #(
      .SCREEN_WIDTH(SCREEN_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_vram_offset(req_vram_offset),
      .req_write_data (req_write_data),
      .req_line       (req_line),
      .req_column     (req_column),
      .queue_full     (queue_full),
      .push           (push),
      .push_entry     (push_entry),
      .bg_palette     (bg_palette)
   );

   // decouple the two sides so each can stall on its own
   tbpf_fifo #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .head      (head),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // drive video memory, look up the shade, hold the result beat
   tbpf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .queue_empty    (queue_empty),
      .pop            (pop),
      .bg_palette     (bg_palette),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_drawn      (rsp_drawn),
      .rsp_shade      (rsp_shade),
      .rsp_color_argb (rsp_color_argb),
      .rsp_pixel_index(rsp_pixel_index)
   );

endmodule

FILE: rtl/tbpf_checker.sv
// Port-level checker for the background pixel fetch, bound to the top level.
`include "assert_macros.svh"

module tbpf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_drawn,
   input logic [1:0]  rsp_shade,
   input logic [31:0] rsp_color_argb,
   input logic [14:0] rsp_pixel_index
);

   `TBPF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp beat dropped while stalled")

   `TBPF_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_pixel_index) && $stable(rsp_color_argb), "rsp payload changed while stalled")

   `TBPF_ASSERT_NOW(a_off_blank, clock, reset, rsp_valid && !rsp_drawn, (rsp_shade == 2'd0) && (rsp_color_argb == 32'h0), "undrawn pixel carries a color")

   `TBPF_ASSERT_NOW(a_color_match, clock, reset, rsp_valid && rsp_drawn, ((rsp_shade == 2'd0) && (rsp_color_argb == 32'hFFFFFFFF)) || ((rsp_shade == 2'd1) && (rsp_color_argb == 32'hFFAAAAAA)) || ((rsp_shade == 2'd2) && (rsp_color_argb == 32'hFF555555)) || ((rsp_shade == 2'd3) && (rsp_color_argb == 32'hFF000000)), "color does not match shade")

endmodule

bind tile_background_pixel_fetch tbpf_checker u_checker (.*);

FILE: bench/tile_background_pixel_fetch_tb.sv
// Self-checking bench for the background pixel fetch: directed corners, random phases.
module tile_background_pixel_fetch_tb;
   import tbpf_pkg::*;

   // request kinds on req_mode
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_PIXEL = 1'b1;

   localparam int ITEM_TARGET = 1450;
   localparam int MAX_WAIT    = 18;
   // enough for a full queue of drawn pixels plus the pipe behind it
   localparam int DRAIN_CYCLES = 4 * QUEUE_DEPTH_DEF + 8;
   // worst case per beat grows with MAX_WAIT on both sides, and fill writes
   // at most quadruple the beat count; this leaves a wide margin on top
   localparam int CYCLE_LIMIT = 1_000_000;

   typedef struct packed {
      logic               mode;
      logic [VRAM_AW-1:0] vram_offset;
      logic [7:0]         write_data;
      logic [7:0]         line;
      logic [7:0]         column;
   } fetch_req_type;

   typedef struct packed {
      logic        drawn;
      logic [1:0]  shade;
      logic [31:0] color_argb;
      logic [14:0] pixel_index;
   } pixel_rsp_type;

   // Shadow of the block: its video memory, its registers and the pixels owed.
   class bg_pixel_scoreboard;
      logic [7:0] vram [VRAM_BYTES];
      bit         written [VRAM_BYTES];
      logic [7:0] lcd_control, scroll_y, scroll_x, bg_palette;
      pixel_rsp_type expected_pixels [$];
      int         errors;

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [7:0] value);
         case (idx)
            CSR_LCD_CONTROL: lcd_control = value;
            CSR_SCROLL_Y:    scroll_y    = value;
            CSR_SCROLL_X:    scroll_x    = value;
            CSR_BG_PALETTE:  bg_palette  = value;
            default: ;
         endcase
      endfunction

      // tile map byte that holds the tile number under a screen pixel
      function logic [VRAM_AW-1:0] map_address(logic [7:0] line, logic [7:0] column);
         logic [7:0]         y, x;
         logic [VRAM_AW-1:0] base;
         y = line + scroll_y;
         x = column + scroll_x;
         base = lcd_control[LCDC_MAP_SELECT] ? MAP_HIGH_BASE : MAP_LOW_BASE;
         return base + {3'b000, y[7:3], x[7:3]};
      endfunction

      // low plane byte of the tile row crossed by a screen line
      function logic [VRAM_AW-1:0] row_address(logic [7:0] tile, logic [7:0] line);
         logic [7:0]         y;
         logic [VRAM_AW-1:0] base;
         y = line + scroll_y;
         if (lcd_control[LCDC_DATA_UNSIGNED])
            base = TILE_UNSIGNED_BASE + {1'b0, tile, 4'b0000};
         else
            base = TILE_SIGNED_BASE + {1'b0, tile ^ TILE_SIGN_FLIP, 4'b0000};
         return base + {9'd0, y[2:0], 1'b0};
      endfunction

      function void take_request(fetch_req_type req);
         pixel_rsp_type      pix;
         logic [VRAM_AW-1:0] row_at;
         logic [7:0]         lo, hi, x;
         logic [2:0]         bit_pos;
         logic [1:0]         color_num;
         int unsigned        flat;
         if (req.mode == MODE_WRITE) begin
            vram[req.vram_offset]    = req.write_data;
            written[req.vram_offset] = 1'b1;
            return;
         end
         flat = req.line * SCREEN_WIDTH_DEF + req.column;
         pix.pixel_index = 15'(flat);
         pix.drawn       = 1'b0;
         pix.shade       = 2'd0;
         pix.color_argb  = 32'd0;
         if (lcd_control[LCDC_BG_ENABLE]) begin
            row_at    = row_address(vram[map_address(req.line, req.column)], req.line);
            lo        = vram[row_at];
            hi        = vram[row_at + 1];
            x         = req.column + scroll_x;
            bit_pos   = 3'd7 - x[2:0];
            color_num = {hi[bit_pos], lo[bit_pos]};
            pix.drawn = 1'b1;
            pix.shade = 2'(bg_palette >> {color_num, 1'b0});
            case (pix.shade)
               2'd0:    pix.color_argb = ARGB_WHITE;
               2'd1:    pix.color_argb = ARGB_LIGHT_GREY;
               2'd2:    pix.color_argb = ARGB_DARK_GREY;
               default: pix.color_argb = ARGB_BLACK;
            endcase
         end
         expected_pixels.push_back(pix);
      endfunction

      function void check_pixel(pixel_rsp_type got);
         pixel_rsp_type want;
         if (expected_pixels.size() == 0) begin
            $error("pixel beat with nothing outstanding, pixel_index %0d", got.pixel_index);
            errors++;
            return;
         end
         want = expected_pixels.pop_front();
         if (got.drawn !== want.drawn) begin
            $error("drawn: expected %0d, got %0d", want.drawn, got.drawn);
            errors++;
         end
         if (got.shade !== want.shade) begin
            $error("shade: expected %0d, got %0d", want.shade, got.shade);
            errors++;
         end
         if (got.color_argb !== want.color_argb) begin
            $error("color_argb: expected %h, got %h", want.color_argb, got.color_argb);
            errors++;
         end
         if (got.pixel_index !== want.pixel_index) begin
            $error("pixel_index: expected %0d, got %0d", want.pixel_index, got.pixel_index);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [7:0]             csr_wdata;
   logic                   req_valid, req_ready;
   logic                   req_mode;
   logic [VRAM_AW-1:0]     req_vram_offset;
   logic [7:0]             req_write_data, req_line, req_column;
   logic                   rsp_valid, rsp_ready;
   logic                   rsp_drawn;
   logic [1:0]             rsp_shade;
   logic [31:0]            rsp_color_argb;
   logic [14:0]            rsp_pixel_index;

   bg_pixel_scoreboard sb;
   bit                 steady;      // phase with no idling on either side
   int                 beats_sent;
   int                 cycle_count = 0;

   tile_background_pixel_fetch DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_vram_offset (req_vram_offset),
      .req_write_data  (req_write_data),
      .req_line        (req_line),
      .req_column      (req_column),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_drawn       (rsp_drawn),
      .rsp_shade       (rsp_shade),
      .rsp_color_argb  (rsp_color_argb),
      .rsp_pixel_index (rsp_pixel_index)
   );

   always #4 clock = ~clock;

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Idle cycles before the next beat on either side; none in a steady phase.
   function automatic int draw_wait();
      if (steady)
         return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // Present one request beat at the falling edge and hold it until accepted.
   // Keep valid high across back-to-back beats; drop it only for a real gap.
   task automatic send_beat(input fetch_req_type req);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= req.mode;
      req_vram_offset <= req.vram_offset;
      req_write_data  <= req.write_data;
      req_line        <= req.line;
      req_column      <= req.column;
      do @(posedge clock); while (!req_ready);
      sb.take_request(req);
      beats_sent++;
      @(negedge clock);
   endtask

   // Store a byte; the pixel fields ride along as noise.
   task automatic send_write(input logic [VRAM_AW-1:0] offset, input logic [7:0] data);
      send_beat('{MODE_WRITE, offset, data, 8'($urandom), 8'($urandom)});
   endtask

   // Ask for a pixel; the write fields ride along as noise.
   task automatic send_pixel(input logic [7:0] line, input logic [7:0] column);
      send_beat('{MODE_PIXEL, 13'($urandom), 8'($urandom), line, column});
   endtask

   // Ask for a pixel, first filling with random bytes any map or tile byte
   // it would read that was never written.
   task automatic fetch_pixel(input logic [7:0] line, input logic [7:0] column);
      logic [VRAM_AW-1:0] tile_at, row_at;
      if (sb.lcd_control[LCDC_BG_ENABLE]) begin
         tile_at = sb.map_address(line, column);
         if (!sb.written[tile_at])
            send_write(tile_at, 8'($urandom));
         row_at = sb.row_address(sb.vram[tile_at], line);
         if (!sb.written[row_at])
            send_write(row_at, 8'($urandom));
         if (!sb.written[row_at + 1])
            send_write(row_at + 13'd1, 8'($urandom));
      end
      send_pixel(line, column);
   endtask

   // Drop valid, wait for every owed pixel, then let queued writes retire.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_pixels.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.write_register(idx, value);
      @(negedge clock);
   endtask

   task automatic configure(input logic [7:0] lcdc, scy, scx, bgp);
      write_csr(CSR_LCD_CONTROL, lcdc);
      write_csr(CSR_SCROLL_Y, scy);
      write_csr(CSR_SCROLL_X, scx);
      write_csr(CSR_BG_PALETTE, bgp);
      csr_we <= 1'b0;
   endtask

   // Result side: stall a random number of cycles, then take one pixel beat.
   initial begin : rsp_side
      int            stall;
      pixel_rsp_type got;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.drawn       = rsp_drawn;
         got.shade       = rsp_shade;
         got.color_argb  = rsp_color_argb;
         got.pixel_index = rsp_pixel_index;
         sb.check_pixel(got);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int         phase, span;
      logic [7:0] lcdc;
      sb              = new;
      steady          = 1'b0;
      beats_sent      = 0;
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = CSR_LCD_CONTROL;
      csr_wdata       = 8'd0;
      req_valid       = 1'b0;
      req_mode        = MODE_WRITE;
      req_vram_offset = '0;
      req_write_data  = 8'd0;
      req_line        = 8'd0;
      req_column      = 8'd0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Registers start at zero: background off. Hit both offset corners,
      // then pixels that stay undrawn, one with a wrapping pixel index.
      send_write(13'h0000, 8'hFF);
      send_write(13'h1FFF, 8'h00);
      send_pixel(8'd0, 8'd0);
      send_pixel(8'd255, 8'd255);

      // Signed tiles from the high map; full scroll wraps pixel (0,0) to the
      // last map byte. Walk its tile number through 0, -128, +127 and -1.
      drain();
      configure(8'h09, 8'hFF, 8'hFF, 8'hE4);
      fetch_pixel(8'd0, 8'd0);
      send_write(13'h1FFF, 8'h80);
      fetch_pixel(8'd0, 8'd0);
      send_write(13'h1FFF, 8'h7F);
      fetch_pixel(8'd0, 8'd0);
      send_write(13'h1FFF, 8'hFF);
      fetch_pixel(8'd0, 8'd0);

      // Unsigned tiles, every control bit set, no scroll: screen corners
      // and a line and column past the screen.
      drain();
      configure(8'hFF, 8'h00, 8'h00, 8'h1B);
      fetch_pixel(8'd0, 8'd0);
      fetch_pixel(8'd143, 8'd159);
      fetch_pixel(8'd255, 8'd255);

      // Random phases: new settings only once the block has gone idle.
      phase = 0;
      while (beats_sent < ITEM_TARGET) begin
         drain();
         case (phase)
            0:       configure(8'hFF, 8'h00, 8'hFF, 8'hE4);
            1:       configure(8'h01, 8'hFF, 8'h00, 8'hFF);
            2:       configure(8'h00, 8'h80, 8'h7F, 8'h00);
            3:       configure(8'hFE, 8'hFF, 8'hFF, 8'h55);
            default: begin
               lcdc = 8'($urandom);
               lcdc[LCDC_BG_ENABLE] = ($urandom_range(0, 4) != 0);
               configure(lcdc, 8'($urandom), 8'($urandom), 8'($urandom));
            end
         endcase
         steady = ($urandom_range(0, 3) == 0);
         span   = $urandom_range(30, 100);
         repeat (span) begin
            // stop the phase early once the item budget is spent
            if (beats_sent >= ITEM_TARGET)
               break;
            if ($urandom_range(0, 9) < 7) begin
               // mostly on-screen pixels, some anywhere the fields reach
               if ($urandom_range(0, 6) == 0)
                  fetch_pixel(8'($urandom), 8'($urandom));
               else
                  fetch_pixel(8'($urandom_range(0, 143)), 8'($urandom_range(0, 159)));
            end else begin
               send_write(13'($urandom), 8'($urandom));
            end
         end
         phase++;
      end

      drain();
      if (sb.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
